// File: rtl/qtr_pkg.sv
// ----------------------------------------------------------------------------
// qtr_pkg
// shared widths and types for the quaternion to rotation matrix block
// ----------------------------------------------------------------------------
`default_nettype none
package qtr_pkg;
  localparam int IN_W    = 16;
  localparam int PROD_W  = 32;
  localparam int NUM_W   = 34;
  localparam int S_W     = 33;
  localparam int Q_W     = 16;
  localparam int OUT_W   = 16;
  localparam int LANES   = 9;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [NUM_W-1:0] num_t;

  typedef struct packed {
    logic              zero;
    logic [S_W-1:0]    s;
    num_t [LANES-1:0]  num;
  } entry_t;
endpackage
`default_nettype wire

// File: rtl/qtr_front.sv
// ----------------------------------------------------------------------------
// qtr_front
// takes quaternions, forms products, then squared magnitude and numerators
// ----------------------------------------------------------------------------
`default_nettype none
module qtr_front import qtr_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     take,
  input  wire logic signed [IN_W-1:0]   quat_x,
  input  wire logic signed [IN_W-1:0]   quat_y,
  input  wire logic signed [IN_W-1:0]   quat_z,
  input  wire logic signed [IN_W-1:0]   quat_w,
  output logic                          inflight,
  output logic                          push,
  output entry_t                        push_data
);
  logic signed [PROD_W-1:0] xx, yy, zz, ww, xy, xz, xw, yz, yw, zw;
  num_t exx, eyy, ezz, eww, exy, exz, exw, eyz, eyw, ezw, s_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 1'b0;
    end else begin
      inflight <= take;
    end
  end

  always_ff @(posedge clk) begin
    xx <= PROD_W'(quat_x) * PROD_W'(quat_x);
    yy <= PROD_W'(quat_y) * PROD_W'(quat_y);
    zz <= PROD_W'(quat_z) * PROD_W'(quat_z);
    ww <= PROD_W'(quat_w) * PROD_W'(quat_w);
    xy <= PROD_W'(quat_x) * PROD_W'(quat_y);
    xz <= PROD_W'(quat_x) * PROD_W'(quat_z);
    xw <= PROD_W'(quat_x) * PROD_W'(quat_w);
    yz <= PROD_W'(quat_y) * PROD_W'(quat_z);
    yw <= PROD_W'(quat_y) * PROD_W'(quat_w);
    zw <= PROD_W'(quat_z) * PROD_W'(quat_w);
  end

  always_comb begin
    exx = NUM_W'(xx);
    eyy = NUM_W'(yy);
    ezz = NUM_W'(zz);
    eww = NUM_W'(ww);
    exy = NUM_W'(xy);
    exz = NUM_W'(xz);
    exw = NUM_W'(xw);
    eyz = NUM_W'(yz);
    eyw = NUM_W'(yw);
    ezw = NUM_W'(zw);
    s_full = exx + eyy + ezz + eww;
    push = inflight;
    push_data.s = s_full[S_W-1:0];
    push_data.zero = (s_full == '0);
    push_data.num[0] = exx + eww - eyy - ezz;
    push_data.num[1] = (exy - ezw) <<< 1;
    push_data.num[2] = (exz + eyw) <<< 1;
    push_data.num[3] = (exy + ezw) <<< 1;
    push_data.num[4] = eyy + eww - exx - ezz;
    push_data.num[5] = (eyz - exw) <<< 1;
    push_data.num[6] = (exz - eyw) <<< 1;
    push_data.num[7] = (eyz + exw) <<< 1;
    push_data.num[8] = ezz + eww - exx - eyy;
  end
endmodule
`default_nettype wire

// File: rtl/qtr_fifo.sv
// ----------------------------------------------------------------------------
// qtr_fifo
// short queue between the front and the divider back end
// ----------------------------------------------------------------------------
`default_nettype none
module qtr_fifo import qtr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire entry_t            push_data,
  input  wire logic              pop,
  output logic                   empty,
  output logic [CNT_W-1:0]       count,
  output entry_t                 pop_data
);
  entry_t mem [0:FIFO_DEPTH-1];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/qtr_back.sv
// ----------------------------------------------------------------------------
// qtr_back
// nine-lane pipelined restoring divider with rounding, one quotient bit a stage
// ----------------------------------------------------------------------------
`default_nettype none
module qtr_back import qtr_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load,
  input  wire entry_t                  load_data,
  output logic                         done,
  output logic                         zero_norm,
  output logic signed [OUT_W-1:0]      entry [0:LANES-1]
);
  logic             vld  [0:Q_W];
  logic             zero [0:Q_W];
  logic [S_W-1:0]   s    [0:Q_W];
  logic [S_W-1:0]   rem  [0:Q_W][0:LANES-1];
  logic [Q_W-1:0]   quo  [0:Q_W][0:LANES-1];
  logic             neg  [0:Q_W][0:LANES-1];

  // abs stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= load;
    end
  end

  always_ff @(posedge clk) begin
    zero[0] <= load_data.zero;
    s[0]    <= load_data.s;
    for (int l = 0; l < LANES; l++) begin
      neg[0][l] <= load_data.num[l][NUM_W-1];
      rem[0][l] <= load_data.num[l][NUM_W-1] ? S_W'(-load_data.num[l])
                                             : S_W'(load_data.num[l]);
      quo[0][l] <= '0;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [S_W:0] cand [0:LANES-1];
    logic [S_W:0] diff [0:LANES-1];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        cand[l] = (k == 0) ? {1'b0, rem[k][l]} : {rem[k][l], 1'b0};
        diff[l] = cand[l] - {1'b0, s[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      zero[k+1] <= zero[k];
      s[k+1]    <= s[k];
      for (int l = 0; l < LANES; l++) begin
        neg[k+1][l] <= neg[k][l];
        if (!diff[l][S_W]) begin
          rem[k+1][l] <= diff[l][S_W-1:0];
          quo[k+1][l] <= {quo[k][l][Q_W-2:0], 1'b1};
        end else begin
          rem[k+1][l] <= cand[l][S_W-1:0];
          quo[k+1][l] <= {quo[k][l][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  // round half away from zero, apply sign, force zero on empty magnitude
  logic [Q_W:0] rnd [0:LANES-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rnd[l] = {1'b0, quo[Q_W][l]} + (Q_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    zero_norm <= zero[Q_W];
    for (int l = 0; l < LANES; l++) begin
      if (zero[Q_W]) begin
        entry[l] <= '0;
      end else if (neg[Q_W][l]) begin
        entry[l] <= -OUT_W'(rnd[l][Q_W:1]);
      end else begin
        entry[l] <= OUT_W'(rnd[l][Q_W:1]);
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/quaternion_to_rotation_matrix_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_top
// normalized 3x3 rotation matrix from a raw q2.14 quaternion
//
// a transaction starts at a rising edge with start high and busy low; the
// four components are sampled at that edge. the nine column-major entries
// and zero_norm appear on the result ports for one cycle with done high.
// one transaction per cycle is taken while busy is low.
// a result passes a product stage, the queue, an abs stage, the 16-stage
// restoring divider, one quotient bit per stage, and a rounding register.
// the front and the divider are parted by a 4-entry queue; busy rises only
// if the queue could overflow, which with a non-stalling back end it never
// does, so busy stays low after reset.
// the receiver cannot stall: every result is presented exactly once.
// synchronous reset rst clears all valid bits and the queue; items in
// flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_to_rotation_matrix_top import qtr_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [IN_W-1:0]  quat_x,
  input  wire logic signed [IN_W-1:0]  quat_y,
  input  wire logic signed [IN_W-1:0]  quat_z,
  input  wire logic signed [IN_W-1:0]  quat_w,
  output logic                         done,
  output logic signed [OUT_W-1:0]      c0_r0,
  output logic signed [OUT_W-1:0]      c0_r1,
  output logic signed [OUT_W-1:0]      c0_r2,
  output logic signed [OUT_W-1:0]      c1_r0,
  output logic signed [OUT_W-1:0]      c1_r1,
  output logic signed [OUT_W-1:0]      c1_r2,
  output logic signed [OUT_W-1:0]      c2_r0,
  output logic signed [OUT_W-1:0]      c2_r1,
  output logic signed [OUT_W-1:0]      c2_r2,
  output logic                         zero_norm
);
  logic               take, inflight, push, empty, pop;
  entry_t             push_data, pop_data;
  logic [CNT_W-1:0]   count;
  logic [CNT_W:0]     occ;
  logic signed [OUT_W-1:0] entry [0:LANES-1];

  assign occ  = {1'b0, count} + (CNT_W+1)'(inflight);
  assign busy = (occ >= (CNT_W+1)'(FIFO_DEPTH));
  assign take = start && !busy;
  assign pop  = !empty;

  qtr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .quat_w    (quat_w),
    .inflight  (inflight),
    .push      (push),
    .push_data (push_data)
  );

  qtr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .empty     (empty),
    .count     (count),
    .pop_data  (pop_data)
  );

  qtr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .load      (pop),
    .load_data (pop_data),
    .done      (done),
    .zero_norm (zero_norm),
    .entry     (entry)
  );

  assign c0_r0 = entry[0];
  assign c0_r1 = entry[1];
  assign c0_r2 = entry[2];
  assign c1_r0 = entry[3];
  assign c1_r1 = entry[4];
  assign c1_r2 = entry[5];
  assign c2_r0 = entry[6];
  assign c2_r1 = entry[7];
  assign c2_r2 = entry[8];
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench for the quaternion to rotation matrix block
//
// drives raw q2.14 quaternions in bursts with random gaps, predicts the nine
// normalized column-major entries and the zero flag for each accepted
// transaction, and checks every result in order against that prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import qtr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic                    zero;
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [IN_W-1:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
  logic busy, done, zero_norm;
  logic signed [OUT_W-1:0] c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2;

  matrix_t expected_matrices[$];
  int mismatch_count = 0;
  int burst_left = 0;

  quaternion_to_rotation_matrix_top uut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // round(16384 * n / s), ties away from zero
  function automatic logic signed [OUT_W-1:0] scaled_entry(longint n, longint s);
    longint mag, q;
    mag = (n < 0 ? -n : n) * 16384;
    q = (2 * mag + s) / (2 * s);
    if (q > 16384) q = 16384;
    return OUT_W'(n < 0 ? -q : q);
  endfunction

  function automatic matrix_t rotation_of(logic signed [IN_W-1:0] qx, qy, qz, qw);
    matrix_t m;
    longint x, y, z, w, s;
    x = qx; y = qy; z = qz; w = qw;
    s = x*x + y*y + z*z + w*w;
    m = '0;
    if (s == 0) begin
      m.zero = 1'b1;
      return m;
    end
    m.m00 = scaled_entry(x*x + w*w - y*y - z*z, s);
    m.m01 = scaled_entry(2 * (x*y - z*w), s);
    m.m02 = scaled_entry(2 * (x*z + y*w), s);
    m.m10 = scaled_entry(2 * (x*y + z*w), s);
    m.m11 = scaled_entry(y*y + w*w - x*x - z*z, s);
    m.m12 = scaled_entry(2 * (y*z - x*w), s);
    m.m20 = scaled_entry(2 * (x*z - y*w), s);
    m.m21 = scaled_entry(2 * (y*z + x*w), s);
    m.m22 = scaled_entry(z*z + w*w - x*x - y*y, s);
    return m;
  endfunction

  // bursts of back-to-back transactions with random gaps
  task automatic send_quat(logic signed [IN_W-1:0] qx, qy, qz, qw);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    start <= 1'b1;
    quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
    do @(posedge clk); while (busy);
    expected_matrices.insert(expected_matrices.size(), rotation_of(qx, qy, qz, qw));
    burst_left--;
  endtask

  function automatic logic signed [IN_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return IN_W'($urandom_range(0, 7) - 4);
      3: return IN_W'($urandom_range(0, 32767) - 16384);
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [IN_W-1:0] v[6];
    v = '{16'sh8000, 16'sh7fff, 16'sh4000, -16'sh4000, 16'sh0001, 16'shffff};
    send_quat(0, 0, 0, 0);
    foreach (v[i]) begin
      send_quat(v[i], 0, 0, 0);
      send_quat(0, v[i], 0, 0);
      send_quat(0, 0, v[i], 0);
    end
    send_quat(0, 0, 0, 16'sh8000);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(16'sh2d41, 0, 0, 16'sh2d41);
    send_quat(1, 1, 1, 1);
    send_quat(0, 0, 0, 0);
  endtask

  task automatic test_random();
    repeat (800) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    start <= 1'b0;
  endtask

  always @(posedge clk) begin
    matrix_t got, exp_m;
    if (!rst && done) begin
      got = '{c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2, zero_norm};
      if (expected_matrices.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected transaction %h", got);
      end else begin
        exp_m = expected_matrices.pop_front();
        if (got !== exp_m) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %h actual %h", exp_m, got);
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random();
    while (expected_matrices.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
